>>> rtl/fat12_cluster_table_engine_unit_assert.svh
// Assertion helpers for the cluster table engine.
// All checks run on clk_i and are off while rst_ni is low.
`ifndef FAT12_CLUSTER_TABLE_ENGINE_UNIT_ASSERT_SVH
`define FAT12_CLUSTER_TABLE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fct_pkg.sv
package fct_pkg;

  // Table geometry
  localparam int TableDepth   = 4096;
  localparam int EntryW       = 12;
  localparam int AddrW        = 28;
  localparam int CountW       = 13;
  localparam int MaxClusters  = 4096;
  localparam int SectorBytes  = 512;
  localparam int DirEntryBytes = 32;
  localparam int SectorShift  = $clog2(SectorBytes);
  localparam int RootShift    = $clog2(SectorBytes / DirEntryBytes);

  localparam logic [EntryW-1:0] TableLast   = EntryW'(TableDepth - 1);
  localparam logic [EntryW-1:0] EndOfChain  = 12'hFFF;
  localparam logic [EntryW-1:0] ChainEndMin = 12'hFF8;
  localparam logic [EntryW-1:0] ScanLimit   = 12'd4085;
  localparam logic [EntryW-1:0] FirstData   = 12'd2;
  localparam logic [CountW-1:0] MaxCount    = CountW'(MaxClusters);

  // Operation codes
  localparam logic [1:0] OpRead  = 2'd0;
  localparam logic [1:0] OpLoad  = 2'd1;
  localparam logic [1:0] OpAlloc = 2'd2;
  localparam logic [1:0] OpFree  = 2'd3;

  // Status codes
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusCutOff  = 2'd2;

  // Register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegPartitionOffset = 3'd0;
  localparam logic [CfgIdxW-1:0] RegReservedSectors = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFatCopies       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFatSectors      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRootEntries     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegClusterSectors  = 3'd5;

  typedef struct packed {
    logic [1:0]        op;
    logic [EntryW-1:0] cluster;
    logic [EntryW-1:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [EntryW-1:0] cluster_out;
    logic [AddrW-1:0]  sector_address;
    logic [CountW-1:0] freed_count;
  } out_item_t;

  typedef struct packed {
    logic [27:0] partition_offset;
    logic [15:0] reserved_sectors;
    logic [2:0]  fat_copies;
    logic [3:0]  fat_sectors;
    logic [15:0] root_entries;
    logic [7:0]  cluster_sectors;
  } cfg_t;

  // Entry pair of cluster c must lie inside the FAT.
  function automatic logic cluster_valid(logic [EntryW-1:0] c, logic [3:0] fat_sectors);
    logic [12:0] need;
    logic [12:0] limit;
    need  = 13'(c) + 13'(c >> 1) + 13'd1;
    limit = 13'(13'(fat_sectors) << SectorShift);
    return (c >= FirstData) && (need < limit);
  endfunction

  function automatic logic walk_continues(logic [EntryW-1:0] c, logic [3:0] fat_sectors);
    return (c < ChainEndMin) && cluster_valid(c, fat_sectors);
  endfunction

endpackage

>>> rtl/fat12_cluster_table_engine_unit.sv
// Channel  | Direction | Handshake                 | Beat
// ---------+-----------+---------------------------+-----------------------------------
// in       | input     | in_valid_i / in_stall_o   | op, cluster, load_value
// out      | output    | out_valid_o / out_stall_i | status, cluster_out, sector_address,
//          |           |                           | freed_count
// cfg      | input     | cfg_we_i (no stall)       | cfg_idx_i, cfg_wdata_i
//
// After reset the table is cleared one entry per cycle, with in_stall_o high.
// Per beat: a load writes its entry directly; a read, and an allocate that finds a
// cluster, wait for the sector unit. Allocate scans and free walks one entry at a time.
// The table RAM (one read, one write per cycle) sets the pace of scan and chain walk.
// One beat is worked on at a time; a new one is taken once the result register is
// empty or being drained. out_stall_i only holds the result register.
module fat12_cluster_table_engine_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fct_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fct_pkg::out_item_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [fct_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [fct_pkg::AddrW-1:0]       cfg_wdata_i
);

  `include "fat12_cluster_table_engine_unit_assert.svh"

  typedef enum logic [2:0] {
    StClr,
    StIdle,
    StRead,
    StAlloc,
    StFree,
    StSec
  } state_e;

  state_e                      state_q, state_d;
  logic [fct_pkg::EntryW-1:0]  clr_q, clr_d;
  logic [fct_pkg::EntryW-1:0]  ptr_q, ptr_d;     // free: current link, alloc: scan slot
  logic [fct_pkg::CountW-1:0]  count_q, count_d;
  logic                        fwd_q, fwd_d;     // read hit the entry cleared last cycle
  logic                        out_valid_q, out_valid_d;
  fct_pkg::out_item_t          out_q, out_d;
  fct_pkg::cfg_t               cfg_q;

  logic                        in_accept;
  logic                        mem_we, mem_re;
  logic [fct_pkg::EntryW-1:0]  mem_waddr, mem_wdata, mem_raddr, rd_data;
  logic                        sec_start, sec_done;
  logic [fct_pkg::EntryW-1:0]  sec_cluster;
  logic [fct_pkg::AddrW-1:0]   sec_addr;
  logic [fct_pkg::EntryW-1:0]  nxt;
  logic [fct_pkg::CountW-1:0]  count_inc;

  fct_table_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  fct_sector_unit u_sector (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .start_i   (sec_start),
    .cluster_i (sec_cluster),
    .done_o    (sec_done),
    .addr_o    (sec_addr)
  );

  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign count_inc  = count_q + 13'd1;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    fwd_d       = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q;
    sec_start   = 1'b0;
    sec_cluster = ptr_q;
    nxt         = '0;

    case (state_q)
      StClr: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 12'd1;
        if (clr_q == fct_pkg::TableLast) begin
          state_d = StIdle;
        end
      end

      StIdle: begin
        if (in_accept) begin
          ptr_d   = in_data_i.cluster;
          count_d = '0;
          out_d   = '0;
          case (in_data_i.op)
            fct_pkg::OpRead: begin
              if (fct_pkg::cluster_valid(in_data_i.cluster, cfg_q.fat_sectors)) begin
                mem_re      = 1'b1;
                mem_raddr   = in_data_i.cluster;
                sec_start   = 1'b1;
                sec_cluster = in_data_i.cluster;
                state_d     = StRead;
              end else begin
                out_d.status = fct_pkg::StatusInvalid;
                out_valid_d  = 1'b1;
              end
            end
            fct_pkg::OpLoad: begin
              mem_we      = 1'b1;
              mem_waddr   = in_data_i.cluster;
              mem_wdata   = in_data_i.load_value;
              out_valid_d = 1'b1;
            end
            fct_pkg::OpAlloc: begin
              if (fct_pkg::cluster_valid(fct_pkg::FirstData, cfg_q.fat_sectors)) begin
                mem_re    = 1'b1;
                mem_raddr = fct_pkg::FirstData;
                ptr_d     = fct_pkg::FirstData;
                state_d   = StAlloc;
              end else begin
                out_d.status = fct_pkg::StatusInvalid;
                out_valid_d  = 1'b1;
              end
            end
            default: begin
              // free chain; a start that ends a chain frees nothing
              if (fct_pkg::walk_continues(in_data_i.cluster, cfg_q.fat_sectors)) begin
                mem_re    = 1'b1;
                mem_raddr = in_data_i.cluster;
                state_d   = StFree;
              end else begin
                out_valid_d = 1'b1;
              end
            end
          endcase
        end
      end

      StRead: begin
        out_d.cluster_out = rd_data;
        state_d           = StSec;
      end

      StAlloc: begin
        if (rd_data == '0) begin
          mem_we            = 1'b1;
          mem_waddr         = ptr_q;
          mem_wdata         = fct_pkg::EndOfChain;
          sec_start         = 1'b1;
          sec_cluster       = ptr_q;
          out_d.cluster_out = ptr_q;
          state_d           = StSec;
        end else begin
          nxt = ptr_q + 12'd1;
          if ((nxt < fct_pkg::ScanLimit) &&
              fct_pkg::cluster_valid(nxt, cfg_q.fat_sectors)) begin
            mem_re    = 1'b1;
            mem_raddr = nxt;
            ptr_d     = nxt;
          end else begin
            out_d.status = fct_pkg::StatusInvalid;
            out_valid_d  = 1'b1;
            state_d      = StIdle;
          end
        end
      end

      StFree: begin
        // clear current link, follow to next in the same cycle
        nxt       = fwd_q ? '0 : rd_data;
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        count_d   = count_inc;
        ptr_d     = nxt;
        if (fct_pkg::walk_continues(nxt, cfg_q.fat_sectors) &&
            (count_inc < fct_pkg::MaxCount)) begin
          mem_re    = 1'b1;
          mem_raddr = nxt;
          fwd_d     = (nxt == ptr_q);
        end else begin
          out_d.status      = fct_pkg::walk_continues(nxt, cfg_q.fat_sectors) ?
                              fct_pkg::StatusCutOff : fct_pkg::StatusOk;
          out_d.freed_count = count_inc;
          out_valid_d       = 1'b1;
          state_d           = StIdle;
        end
      end

      StSec: begin
        if (sec_done) begin
          out_d.sector_address = sec_addr;
          out_valid_d          = 1'b1;
          state_d              = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClr;
      clr_q       <= '0;
      count_q     <= '0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      fwd_q       <= fwd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    out_q <= out_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.partition_offset <= 28'd0;
      cfg_q.reserved_sectors <= 16'd1;
      cfg_q.fat_copies       <= 3'd2;
      cfg_q.fat_sectors      <= 4'd9;
      cfg_q.root_entries     <= 16'd224;
      cfg_q.cluster_sectors  <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fct_pkg::RegPartitionOffset: cfg_q.partition_offset <= cfg_wdata_i;
        fct_pkg::RegReservedSectors: cfg_q.reserved_sectors <= cfg_wdata_i[15:0];
        fct_pkg::RegFatCopies:       cfg_q.fat_copies       <= cfg_wdata_i[2:0];
        fct_pkg::RegFatSectors:      cfg_q.fat_sectors      <= cfg_wdata_i[3:0];
        fct_pkg::RegRootEntries:     cfg_q.root_entries     <= cfg_wdata_i[15:0];
        fct_pkg::RegClusterSectors:  cfg_q.cluster_sectors  <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FCT_ASSERT_NOW(a_walk_bound, state_q == StFree, count_q < fct_pkg::MaxCount, "walk past bound")
  `FCT_ASSERT_NOW(a_scan_bound, state_q == StAlloc, ptr_q < fct_pkg::ScanLimit, "scan past limit")
  `FCT_ASSERT_NOW(a_sec_owner, sec_done, state_q == StSec, "sector result unclaimed")
  `FCT_ASSERT_NOW(a_fwd_free, fwd_q, state_q == StFree, "forward outside chain walk")
  `FCT_ASSERT_NEXT(a_load_done, in_accept && (in_data_i.op == fct_pkg::OpLoad), out_valid_q && (out_q.status == fct_pkg::StatusOk), "load gave no result")

endmodule

>>> rtl/fct_table_ram.sv
module fct_table_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [fct_pkg::EntryW-1:0] waddr_i,
  input  logic [fct_pkg::EntryW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [fct_pkg::EntryW-1:0] raddr_i,
  output logic [fct_pkg::EntryW-1:0] rdata_o
);

  logic [fct_pkg::EntryW-1:0] mem_q [fct_pkg::TableDepth];
  logic [fct_pkg::EntryW-1:0] rdata_q;

  // Read returns the old word on a same-address write; caller forwards.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/fct_sector_unit.sv
module fct_sector_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fct_pkg::cfg_t               cfg_i,
  input  logic                        start_i,
  input  logic [fct_pkg::EntryW-1:0]  cluster_i,
  output logic                        done_o,
  output logic [fct_pkg::AddrW-1:0]   addr_o
);

  logic [19:0]               prod_d, prod_q;
  logic [fct_pkg::AddrW-1:0] base_d, base_q;
  logic [6:0]                fat_area;
  logic                      low_d, low_q;
  logic                      stage_q;
  logic                      done_q;
  logic [fct_pkg::AddrW-1:0] addr_q;

  // Stage 1: cluster offset product and volume base.
  always_comb begin
    fat_area = 7'(cfg_i.fat_copies) * 7'(cfg_i.fat_sectors);
    prod_d   = 20'(cluster_i - fct_pkg::FirstData) * 20'(cfg_i.cluster_sectors);
    base_d   = cfg_i.partition_offset
             + 28'(cfg_i.reserved_sectors)
             + 28'(fat_area)
             + 28'(cfg_i.root_entries >> fct_pkg::RootShift);
    low_d    = cluster_i < fct_pkg::FirstData;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= start_i;
      done_q  <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_d;
      base_q <= base_d;
      low_q  <= low_d;
    end
    // Stage 2: final add, wraps to 28 bits.
    if (stage_q) begin
      addr_q <= low_q ? '0 : base_q + 28'(prod_q);
    end
  end

  assign done_o = done_q;
  assign addr_o = addr_q;

endmodule

>>> dv/fat12_cluster_table_engine_unit_test.sv
`timescale 1ns / 100ps

module fat12_cluster_table_engine_unit_test;

  localparam int unsigned CycleLimit = 4_000_000;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // DUT ports; every input starts from a known value
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  fct_pkg::in_item_t            in_data_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  fct_pkg::out_item_t           out_data_o;
  logic                         cfg_we_i = 1'b0;
  logic [fct_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [fct_pkg::AddrW-1:0]    cfg_wdata_i = '0;

  fat12_cluster_table_engine_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow of the volume geometry, starting at the reset values
  int unsigned cfg_part   = 0;
  int unsigned cfg_rsvd   = 1;
  int unsigned cfg_copies = 2;
  int unsigned cfg_fatsec = 9;
  int unsigned cfg_root   = 224;
  int unsigned cfg_clsec  = 1;

  // Shadow of the cluster table
  logic [fct_pkg::EntryW-1:0] fat_shadow [fct_pkg::TableDepth];

  // Beats waiting to be sent, and replies the shadow table says must come back
  fct_pkg::in_item_t  fat_cmd_q [$];
  fct_pkg::out_item_t fat_reply_q [$];

  int unsigned queued_total = 0;
  int unsigned beats_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned op_hits [4]  = '{0, 0, 0, 0};
  int unsigned refusals     = 0;
  int unsigned freed_total  = 0;
  int unsigned hold_left    = 0;
  bit          held_once    = 1'b0;
  fct_pkg::out_item_t due_result;
  fct_pkg::out_item_t oldest_reply;

  // ---------------------------------------------------------------------------
  // Shadow model of the engine
  // ---------------------------------------------------------------------------

  // A cluster counts only while its packed entry pair sits inside one FAT copy.
  function automatic bit fits_in_fat(int unsigned c);
    return (c >= fct_pkg::FirstData) && ((c + c / 2 + 1) < cfg_fatsec * fct_pkg::SectorBytes);
  endfunction

  function automatic bit chain_goes_on(int unsigned c);
    return (c < fct_pkg::ChainEndMin) && fits_in_fat(c);
  endfunction

  // First sector of a data cluster: volume start, reserved area, all FAT copies,
  // the root directory, then whole clusters. Wraps at 28 bits.
  function automatic logic [fct_pkg::AddrW-1:0] sector_of(int unsigned c);
    longint unsigned a;
    if (c < fct_pkg::FirstData) return '0;
    a = longint'(cfg_part) + longint'(cfg_rsvd);
    a += longint'(cfg_copies) * longint'(cfg_fatsec);
    a += (longint'(cfg_root) * fct_pkg::DirEntryBytes) / fct_pkg::SectorBytes;
    a += longint'(c - 2) * longint'(cfg_clsec);
    return a[fct_pkg::AddrW-1:0];
  endfunction

  function automatic fct_pkg::out_item_t fat_engine_step(fct_pkg::in_item_t b);
    fct_pkg::out_item_t r;
    int unsigned c;
    int unsigned cur;
    int unsigned nxt;
    int unsigned k;
    int unsigned cnt;
    bit          found;
    r = '0;
    c = b.cluster;
    case (b.op)
      fct_pkg::OpRead: begin
        if (fits_in_fat(c)) begin
          r.cluster_out    = fat_shadow[c];
          r.sector_address = sector_of(c);
        end else begin
          r.status = fct_pkg::StatusInvalid;
        end
      end
      fct_pkg::OpLoad: begin
        // no bound check at all on a load
        fat_shadow[c] = b.load_value;
      end
      fct_pkg::OpAlloc: begin
        r.status = fct_pkg::StatusInvalid;
        found = 1'b0;
        for (k = fct_pkg::FirstData; k < fct_pkg::ScanLimit && fits_in_fat(k) && !found;
             k++) begin
          if (fat_shadow[k] == '0) begin
            fat_shadow[k]    = fct_pkg::EndOfChain;
            r.status         = fct_pkg::StatusOk;
            r.cluster_out    = k[fct_pkg::EntryW-1:0];
            r.sector_address = sector_of(k);
            found = 1'b1;
          end
        end
      end
      fct_pkg::OpFree: begin
        cur = c;
        cnt = 0;
        // Clearing as we go means a looped chain ends after one extra step.
        while (chain_goes_on(cur) && cnt < fct_pkg::MaxClusters) begin
          nxt = fat_shadow[cur];
          fat_shadow[cur] = '0;
          cnt++;
          cur = nxt;
        end
        if (chain_goes_on(cur)) r.status = fct_pkg::StatusCutOff;
        r.freed_count = cnt[fct_pkg::CountW-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_beat(logic [1:0] op, int unsigned c, int unsigned v);
    fct_pkg::in_item_t b;
    b.op         = op;
    b.cluster    = c[fct_pkg::EntryW-1:0];
    b.load_value = v[fct_pkg::EntryW-1:0];
    fat_cmd_q.push_back(b);
    queued_total++;
  endfunction

  // Mostly clusters inside the window, now and then the edges or anything at all.
  function automatic int unsigned pick_cluster(int unsigned window);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, fct_pkg::TableDepth - 1);
      1:       return $urandom_range(0, 1) ? window + 1 : $urandom_range(0, 1);
      default: return $urandom_range(fct_pkg::FirstData, window);
    endcase
  endfunction

  // Builds chains with loads and tears them down with frees, plus allocates,
  // reads and raw noise. Loads land in the window so later beats see them.
  task automatic queue_random(input int unsigned n, input int unsigned window);
    int unsigned start;
    int unsigned len;
    int unsigned links [5];
    int unsigned tail;
    int unsigned pick;
    start = queued_total;
    while (queued_total - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) links[i] = $urandom_range(fct_pkg::FirstData, window);
        for (int i = 0; i + 1 < len; i++) add_beat(fct_pkg::OpLoad, links[i], links[i + 1]);
        case ($urandom_range(0, 4))
          0:       tail = fct_pkg::EndOfChain;
          1:       tail = $urandom_range(fct_pkg::ChainEndMin, fct_pkg::EndOfChain);
          2:       tail = $urandom_range(0, 1);
          3:       tail = links[0];                      // loops back to the head
          default: tail = $urandom_range(0, fct_pkg::TableDepth - 1);
        endcase
        add_beat(fct_pkg::OpLoad, links[len - 1], tail);
        if ($urandom_range(0, 1)) add_beat(fct_pkg::OpRead, links[0], $urandom);
        add_beat(fct_pkg::OpFree, links[$urandom_range(0, len - 1)], $urandom);
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 3)) add_beat(fct_pkg::OpAlloc, $urandom, $urandom);
        if ($urandom_range(0, 1)) add_beat(fct_pkg::OpFree, pick_cluster(window), $urandom);
      end else if (pick < 85) begin
        add_beat(fct_pkg::OpRead, pick_cluster(window), $urandom);
      end else begin
        add_beat(2'($urandom_range(0, 3)), $urandom, $urandom);
      end
    end
  endtask

  // Quiet means nothing queued, nothing offered and no reply outstanding.
  task automatic wait_quiet(input int unsigned settle);
    @(negedge clk_i);
    while (fat_cmd_q.size() != 0 || in_valid_i || fat_reply_q.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [fct_pkg::CfgIdxW-1:0] idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[fct_pkg::AddrW-1:0];
    case (idx)
      fct_pkg::RegPartitionOffset: cfg_part   = value & 32'h0FFF_FFFF;
      fct_pkg::RegReservedSectors: cfg_rsvd   = value & 32'hFFFF;
      fct_pkg::RegFatCopies:       cfg_copies = value & 32'h7;
      fct_pkg::RegFatSectors:      cfg_fatsec = value & 32'hF;
      fct_pkg::RegRootEntries:     cfg_root   = value & 32'hFFFF;
      fct_pkg::RegClusterSectors:  cfg_clsec  = value & 32'hFF;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(input int unsigned part, input int unsigned rsvd,
                               input int unsigned copies, input int unsigned fatsec,
                               input int unsigned root, input int unsigned clsec);
    set_reg(fct_pkg::RegPartitionOffset, part);
    set_reg(fct_pkg::RegReservedSectors, rsvd);
    set_reg(fct_pkg::RegFatCopies, copies);
    set_reg(fct_pkg::RegFatSectors, fatsec);
    set_reg(fct_pkg::RegRootEntries, root);
    set_reg(fct_pkg::RegClusterSectors, clsec);
    end_writes();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers beats from the command queue, holds a beat until taken.
  // Idles ~14% of cycles, except for a calm stretch in the middle of the run.
  // The reply is predicted the moment a beat is taken, since the engine works
  // strictly one beat at a time in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        due_result = fat_engine_step(in_data_i);
        fat_reply_q.push_back(due_result);
        beats_sent++;
        op_hits[in_data_i.op]++;
        if (due_result.status != fct_pkg::StatusOk) refusals++;
        freed_total += due_result.freed_count;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (fat_cmd_q.size() != 0 &&
            ((beats_sent >= 90 && beats_sent < 125) || $urandom_range(0, 99) >= 14)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= fat_cmd_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes replies, checks them against the oldest prediction, and
  // drives the stall. Once, early on, it holds the stall so the engine
  // backs up and stalls its input while the driver keeps offering.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string label, logic [fct_pkg::AddrW-1:0] want,
                                      logic [fct_pkg::AddrW-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (fat_reply_q.size() == 0) begin
          $display("%0t ns: unexpected reply beat, expected none, actual 0x%0h",
                   $time, out_data_o);
          mismatches++;
        end else begin
          oldest_reply = fat_reply_q.pop_front();
          check_field("status", oldest_reply.status, out_data_o.status);
          check_field("cluster_out", oldest_reply.cluster_out, out_data_o.cluster_out);
          check_field("sector_address", oldest_reply.sector_address,
                      out_data_o.sector_address);
          check_field("freed_count", oldest_reply.freed_count, out_data_o.freed_count);
        end
        results_seen++;
      end
      if (results_seen == 30 && !held_once) begin
        held_once = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !(results_seen >= 90 && results_seen < 125) &&
                       ($urandom_range(0, 99) < 14);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < fct_pkg::TableDepth; i++) fat_shadow[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats on the reset geometry (9 sectors per FAT: 3071 is the
    // last valid cluster). The engine first clears its table for a while.
    @(negedge clk_i);
    add_beat(fct_pkg::OpRead, 0, 12'hFFF);          // below the first data cluster
    add_beat(fct_pkg::OpRead, 3071, 0);             // last cluster inside the FAT
    add_beat(fct_pkg::OpRead, 3072, 0);             // first one past it
    add_beat(fct_pkg::OpLoad, 0, 12'hFFF);          // loads ignore the bound
    add_beat(fct_pkg::OpLoad, 4095, 12'hABC);
    add_beat(fct_pkg::OpLoad, 2, 3);
    add_beat(fct_pkg::OpLoad, 3, 12'hFFF);
    add_beat(fct_pkg::OpRead, 2, 0);
    add_beat(fct_pkg::OpFree, 2, 0);                // two-entry chain
    add_beat(fct_pkg::OpAlloc, 0, 0);               // gets 2 back
    add_beat(fct_pkg::OpAlloc, 4095, 12'hFFF);      // then 3
    add_beat(fct_pkg::OpFree, 0, 0);                // start below 2: nothing freed
    add_beat(fct_pkg::OpFree, 4095, 0);             // start at or above the end marks
    add_beat(fct_pkg::OpFree, 3072, 0);             // start outside the FAT
    add_beat(fct_pkg::OpLoad, 10, 11);
    add_beat(fct_pkg::OpLoad, 11, 10);
    add_beat(fct_pkg::OpFree, 10, 0);               // looped chain
    add_beat(fct_pkg::OpLoad, 20, 12'hFF8);
    add_beat(fct_pkg::OpFree, 20, 0);               // lowest end-of-chain mark
    add_beat(fct_pkg::OpLoad, 30, 3072);
    add_beat(fct_pkg::OpFree, 30, 0);               // next points outside the FAT
    wait_quiet(8);

    // Top of every range; the sector address wraps at 28 bits.
    apply_setting(28'hFFF_FFFF, 16'hFFFF, 4, 12, 16'hFFFF, 128);
    @(negedge clk_i);
    queue_random(30, 500);
    wait_quiet(8);

    // Bottom of every range: one sector per FAT, clusters 2..340 only.
    apply_setting(0, 0, 1, 1, 0, 1);
    @(negedge clk_i);
    queue_random(25, 340);
    wait_quiet(8);

    // Random geometry, with a full drain halfway through.
    cfg_fatsec = $urandom_range(1, 12);
    apply_setting($urandom_range(0, 28'hFFF_FFFF), $urandom_range(0, 16'hFFFF),
                  $urandom_range(1, 4), cfg_fatsec, $urandom_range(0, 16'hFFFF),
                  $urandom_range(1, 128));
    @(negedge clk_i);
    queue_random(15, (cfg_fatsec * 341 - 1 < 600) ? cfg_fatsec * 341 - 1 : 600);
    wait_quiet(0);
    queue_random(15, (cfg_fatsec * 341 - 1 < 600) ? cfg_fatsec * 341 - 1 : 600);
    wait_quiet(8);

    // Empty FAT: nothing is valid, so allocate finds no free cluster.
    set_reg(fct_pkg::RegFatSectors, 0);
    end_writes();
    @(negedge clk_i);
    add_beat(fct_pkg::OpAlloc, 0, 0);
    add_beat(fct_pkg::OpRead, 5, 0);
    add_beat(fct_pkg::OpFree, 5, 0);
    add_beat(fct_pkg::OpLoad, 5, 7);
    add_beat(fct_pkg::OpRead, 5, 0);
    wait_quiet(8);

    // Outside the documented ranges: seven copies, 15 sectors per FAT, and
    // zero sectors per cluster so every cluster shares one address.
    apply_setting($urandom_range(0, 28'hFFF_FFFF), $urandom_range(0, 16'hFFFF), 7, 15,
                  $urandom_range(0, 16'hFFFF), 0);
    @(negedge clk_i);
    queue_random(30, 600);
    wait_quiet(64);

    $display("Summary: %0d beats (%0d read, %0d load, %0d allocate, %0d free)",
             beats_sent, op_hits[fct_pkg::OpRead], op_hits[fct_pkg::OpLoad],
             op_hits[fct_pkg::OpAlloc], op_hits[fct_pkg::OpFree]);
    $display("Summary: six geometries, %0d replies refused or invalid, %0d entries freed",
             refusals, freed_total);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/fct_pkg.sv
rtl/fct_table_ram.sv
rtl/fct_sector_unit.sv
rtl/fat12_cluster_table_engine_unit.sv
dv/fat12_cluster_table_engine_unit_test.sv
